@@ rtl/insa_pkg.sv @@
// ----------------------------------------------------------------------------
// insa_pkg
// Shared types and constants of the in-network sum aggregator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package insa_pkg;

  // Tree and slot geometry
  localparam int FanIn        = 2;
  localparam int Window       = 8;
  localparam int Slots        = 2 * Window;
  localparam int PayloadWords = 64;

  localparam int SlotW    = $clog2(Slots);
  localparam int RamDepth = Slots * PayloadWords;
  localparam int AddrW    = $clog2(RamDepth);
  localparam int ChildW   = (FanIn > 1) ? $clog2(FanIn) : 1;
  localparam int IdxW     = $clog2(FanIn + 1);

  // Field widths
  localparam int PortW = 2;
  localparam int OpW   = 8;
  localparam int PsnW  = 24;
  localparam int WiW   = 6;
  localparam int SumW  = 32;
  localparam int RethW = 128;
  localparam int DegW  = 8;

  // Generation tag kept beside each sum word; wide enough that the
  // background scrubber revisits every word before the tag can wrap
  localparam int GenW = 12;
  localparam int RamW = GenW + SumW;

  // Transport opcodes
  localparam logic [OpW-1:0] OpSendFirst   = 8'h00;
  localparam logic [OpW-1:0] OpSendMiddle  = 8'h01;
  localparam logic [OpW-1:0] OpSendLast    = 8'h02;
  localparam logic [OpW-1:0] OpSendOnly    = 8'h04;
  localparam logic [OpW-1:0] OpWriteFirst  = 8'h06;
  localparam logic [OpW-1:0] OpWriteMiddle = 8'h07;
  localparam logic [OpW-1:0] OpWriteLast   = 8'h08;
  localparam logic [OpW-1:0] OpWriteOnly   = 8'h0A;
  localparam logic [OpW-1:0] OpAck         = 8'h11;

  typedef enum logic [2:0] {
    ActNone,
    ActAcc,
    ActAccBcast,
    ActAccUp,
    ActResendChild,
    ActResendUp,
    ActDown
  } act_e;

  typedef enum logic [1:0] {
    KindData,
    KindReth,
    KindAck
  } kind_e;

  typedef enum logic [1:0] {
    StInit,
    StIdle,
    StMod,
    StEmit
  } state_e;

  // Per-packet decision latched on word 0
  typedef struct packed {
    logic valid;
    logic reth;
    act_e act;
  } action_t;

endpackage

@@ rtl/insa_ram.sv @@
// ----------------------------------------------------------------------------
// insa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module insa_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, old data on a same-address write
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/in_network_sum_aggregator.sv @@
// ----------------------------------------------------------------------------
// in_network_sum_aggregator
// Slot-pool sum aggregation switch: one payload word per input beat; child
// words are summed per slot and word, then broadcast or sent to the parent,
// parent words are broadcast, retransmissions are answered from the slot and
// child ACKs are reflected. The sums live in one RAM with registered read;
// arrival bits, degree counts and kept RETH values live in flip-flops.
// Flow: each input beat is taken in the idle state, read-modify-written in
// the update state and then sends its result beats (one, or FAN_IN for a
// broadcast) from the emit state, which waits while the output is stalled;
// the next beat is taken only after that. The single sum RAM port pair and
// the one output register set this. After reset the block clears all 1024
// sum RAM words (one per cycle) and accepts no beat until it is done; the
// configuration port is always ready. A background scrubber refreshes the
// generation tags of the sum words in turn whenever the RAM is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module in_network_sum_aggregator (
  input  logic          clk_i,
  input  logic          rst_ni,
  // Configuration: is_root
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_data_i,
  // Input beats
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // in_port, psn, word_index, data_word, in_reth_addr, in_reth_key,
  // in_reth_length
  input  logic [191:0]  s_axis_tdata,
  // opcode
  input  logic [7:0]    s_axis_tuser,
  // Result beats
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // egress_port, out_opcode, out_psn, out_word_index, out_word,
  // out_reth_addr, out_reth_key, out_reth_length
  output logic [199:0]  m_axis_tdata,
  // out_kind, out_reth_valid
  output logic [2:0]    m_axis_tuser,
  // last_result
  output logic          m_axis_tlast
);

  import insa_pkg::*;

  state_e state_q, state_d;
  logic   is_root_q;

  // Captured input beat
  logic [PortW-1:0] port_q;
  logic [OpW-1:0]   op_q;
  logic [PsnW-1:0]  psn_q;
  logic [WiW-1:0]   wi_q;
  logic [SumW-1:0]  word_q;
  logic [RethW-1:0] reth_in_q;

  // Slot state
  action_t          act_q;
  logic [FanIn:0]   arr_q   [Slots];
  logic [DegW-1:0]  deg_q   [Slots];
  logic [GenW-1:0]  gen_q   [Slots];
  logic [FanIn-1:0] rv_q    [Slots];
  logic [RethW-1:0] reth_q  [Slots][FanIn];

  // Emit context
  logic [SumW-1:0]  sum_q;
  act_e             em_act_q;
  logic             em_ack_q;
  logic             em_reth_q;
  logic [IdxW-1:0]  em_n_q;
  logic [IdxW-1:0]  em_idx_q;

  // Output register
  logic             m_valid_q;
  logic [199:0]     m_data_q;
  logic [2:0]       m_user_q;
  logic             m_last_q;

  // Scrubber
  logic [AddrW-1:0] scr_ptr_q;
  logic             scr_rd_q;
  logic             scr_hit_q;

  // RAM port
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [RamW-1:0]  ram_wdata;
  logic [AddrW-1:0] ram_raddr;
  logic [RamW-1:0]  ram_rdata;

  logic acc;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == StIdle);
  assign cfg_ready_o   = 1'b1;

  // --------------------------------------------------------------------------
  // Decode of the captured beat
  // --------------------------------------------------------------------------
  logic [SlotW-1:0] slot, clr_slot;
  logic [AddrW-1:0] item_addr, in_addr;
  logic             is_ack, data_op, write_op, is_child, item_ok, run, ack_ok;
  logic [FanIn:0]   bits, nb;
  logic [DegW-1:0]  deg_new;
  logic             all_kids;
  logic [ChildW-1:0] port_c;

  assign slot      = SlotW'(psn_q % Slots);
  assign clr_slot  = SlotW'((25'(psn_q) + 25'(Window)) % Slots);
  assign item_addr = AddrW'(32'(slot) * PayloadWords + 32'(wi_q));
  assign in_addr   = AddrW'((s_axis_tdata[25:2] % Slots) * PayloadWords
                            + 32'(s_axis_tdata[31:26]));
  assign is_ack    = (op_q == OpAck);
  assign data_op   = (op_q == OpSendFirst) || (op_q == OpSendMiddle) ||
                     (op_q == OpSendLast) || (op_q == OpSendOnly) ||
                     (op_q == OpWriteMiddle) || (op_q == OpWriteLast);
  assign write_op  = (op_q == OpWriteFirst) || (op_q == OpWriteOnly);
  assign is_child  = (port_q < PortW'(FanIn));
  assign port_c    = port_q[ChildW-1:0];
  assign item_ok   = (port_q <= PortW'(FanIn)) && !is_ack && (data_op || write_op)
                     && (32'(wi_q) < PayloadWords);
  assign run       = item_ok && ((wi_q == '0) || act_q.valid);
  assign ack_ok    = is_ack && is_child;
  assign bits      = arr_q[slot];
  assign all_kids  = &bits[FanIn-1:0];
  assign deg_new   = deg_q[slot] + DegW'(1);

  // Packet decision on word 0
  act_e dec_act;
  logic upd_bits, keep, do_clr;

  always_comb begin
    dec_act  = ActNone;
    nb       = bits;
    upd_bits = 1'b0;
    keep     = 1'b0;
    do_clr   = 1'b0;
    if (is_child) begin
      if (bits[port_c]) begin
        if (bits[FanIn]) begin
          dec_act = ActResendChild;
        end else if (!is_root_q && all_kids && ((deg_new % FanIn) == 0)) begin
          dec_act = ActResendUp;
        end
      end else begin
        upd_bits = 1'b1;
        keep     = write_op;
        nb       = bits | ((FanIn + 1)'(1) << port_q);
        if (&nb[FanIn-1:0]) begin
          do_clr = 1'b1;
          if (is_root_q) begin
            nb[FanIn] = 1'b1;
            dec_act   = ActAccBcast;
          end else begin
            dec_act = ActAccUp;
          end
        end else begin
          dec_act = ActAcc;
        end
      end
    end else if (!bits[FanIn] && all_kids) begin
      upd_bits  = 1'b1;
      nb[FanIn] = 1'b1;
      dec_act   = ActDown;
    end
  end

  action_t eff;
  logic    dec_en;
  assign dec_en = (state_q == StMod) && item_ok && (wi_q == '0);

  always_comb begin
    if (wi_q == '0) begin
      eff = '{valid: 1'b1, reth: write_op, act: dec_act};
    end else begin
      eff = act_q;
    end
  end

  // Sum update from the RAM word read at accept
  logic [GenW-1:0] rd_tag;
  logic [SumW-1:0] rd_val, old_sum, new_sum;
  logic            sum_wr;
  logic [IdxW-1:0] n_out;

  assign rd_tag  = ram_rdata[RamW-1:SumW];
  assign rd_val  = ram_rdata[SumW-1:0];
  assign old_sum = (rd_tag == gen_q[slot]) ? rd_val : '0;

  always_comb begin
    new_sum = old_sum;
    sum_wr  = 1'b0;
    n_out   = '0;
    case (eff.act)
      ActAcc: begin
        new_sum = old_sum + word_q;
        sum_wr  = 1'b1;
      end
      ActAccBcast: begin
        new_sum = old_sum + word_q;
        sum_wr  = 1'b1;
        n_out   = IdxW'(FanIn);
      end
      ActAccUp: begin
        new_sum = old_sum + word_q;
        sum_wr  = 1'b1;
        n_out   = IdxW'(1);
      end
      ActDown: begin
        new_sum = word_q;
        sum_wr  = 1'b1;
        n_out   = IdxW'(FanIn);
      end
      ActResendUp: n_out = IdxW'(1);
      ActResendChild: n_out = is_child ? IdxW'(1) : '0;
      default: ;
    endcase
    if (!run) begin
      sum_wr = 1'b0;
      n_out  = ack_ok ? IdxW'(1) : '0;
    end
  end

  logic item_we;
  assign item_we = (state_q == StMod) && sum_wr;

  // --------------------------------------------------------------------------
  // Sum RAM, clearing pass and scrubber
  // --------------------------------------------------------------------------
  logic [SlotW-1:0] scr_slot;
  logic             scr_we, init_we;
  logic [RamW-1:0]  scr_fix;

  assign scr_slot = SlotW'(scr_ptr_q / PayloadWords);
  assign scr_fix  = {gen_q[scr_slot],
                     (rd_tag == gen_q[scr_slot]) ? rd_val : {SumW{1'b0}}};
  assign init_we  = (state_q == StInit);
  assign scr_we   = !init_we && scr_rd_q && !scr_hit_q && !item_we;

  always_comb begin
    ram_we    = item_we || scr_we || init_we;
    ram_waddr = item_we ? item_addr : scr_ptr_q;
    ram_raddr = acc ? in_addr : scr_ptr_q;
    if (item_we) begin
      ram_wdata = {gen_q[slot], new_sum};
    end else if (init_we) begin
      ram_wdata = '0;
    end else begin
      ram_wdata = scr_fix;
    end
  end

  insa_ram #(
    .Width (RamW),
    .Depth (RamDepth)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Advance the sweep pointer, drop a scrub read that an item write overtook
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_ptr_q <= '0;
      scr_rd_q  <= 1'b0;
      scr_hit_q <= 1'b0;
    end else begin
      if (init_we || scr_we) begin
        scr_ptr_q <= (32'(scr_ptr_q) == RamDepth - 1) ? '0 : scr_ptr_q + AddrW'(1);
      end
      scr_rd_q  <= !init_we && !acc && !scr_rd_q;
      scr_hit_q <= item_we && (item_addr == scr_ptr_q);
    end
  end

  // --------------------------------------------------------------------------
  // Control state machine
  // --------------------------------------------------------------------------
  logic load;
  assign load = (state_q == StEmit) && (!m_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StInit: if (32'(scr_ptr_q) == RamDepth - 1) state_d = StIdle;
      StIdle: if (acc) state_d = StMod;
      StMod: state_d = (n_out != '0) ? StEmit : StIdle;
      StEmit: if (load && (em_idx_q == em_n_q - IdxW'(1))) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_root_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      is_root_q <= cfg_data_i;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk_i) begin
    if (acc) begin
      port_q    <= s_axis_tdata[1:0];
      psn_q     <= s_axis_tdata[25:2];
      wi_q      <= s_axis_tdata[31:26];
      word_q    <= s_axis_tdata[63:32];
      reth_in_q <= s_axis_tdata[191:64];
      op_q      <= s_axis_tuser;
    end
  end

  // Slot control state: latch, arrival bits, degree, generation, RETH valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= '{valid: 1'b0, reth: 1'b0, act: ActNone};
      for (int s = 0; s < Slots; s++) begin
        arr_q[s] <= '0;
        deg_q[s] <= '0;
        gen_q[s] <= '0;
        rv_q[s]  <= '0;
      end
    end else begin
      if (dec_en) begin
        act_q <= eff;
        if (is_child) begin
          deg_q[slot] <= deg_new;
        end
        if (upd_bits) begin
          arr_q[slot] <= nb;
        end
        if (keep) begin
          rv_q[slot][port_c] <= 1'b1;
        end
        if (do_clr) begin
          arr_q[clr_slot] <= '0;
          deg_q[clr_slot] <= '0;
          rv_q[clr_slot]  <= '0;
          gen_q[clr_slot] <= gen_q[clr_slot] + GenW'(1);
        end
      end
      if ((state_q == StMod) && run && (32'(wi_q) == PayloadWords - 1)) begin
        act_q <= '{valid: 1'b0, reth: 1'b0, act: ActNone};
      end
    end
  end

  // Kept RETH payload
  always_ff @(posedge clk_i) begin
    if (dec_en && keep) begin
      reth_q[slot][port_c] <= reth_in_q;
    end
  end

  // Hold the emit context
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_n_q   <= '0;
      em_idx_q <= '0;
    end else if (state_q == StMod) begin
      em_n_q   <= n_out;
      em_idx_q <= '0;
    end else if (load) begin
      em_idx_q <= em_idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StMod) begin
      sum_q     <= new_sum;
      em_act_q  <= eff.act;
      em_ack_q  <= !run;
      em_reth_q <= eff.reth;
    end
  end

  // --------------------------------------------------------------------------
  // Result beat
  // --------------------------------------------------------------------------
  logic [PortW-1:0]  egress;
  logic [ChildW-1:0] eg_c;
  logic              to_child, rv_out;
  kind_e             kind;
  logic [RethW-1:0]  reth_out;

  always_comb begin
    if (em_ack_q) begin
      egress = port_q;
    end else begin
      case (em_act_q)
        ActAccBcast, ActDown: egress = PortW'(em_idx_q);
        ActAccUp, ActResendUp: egress = PortW'(FanIn);
        default: egress = port_q;
      endcase
    end
  end

  assign eg_c     = egress[ChildW-1:0];
  assign to_child = (egress < PortW'(FanIn));
  assign rv_out   = !em_ack_q && em_reth_q && to_child;
  assign reth_out = (rv_out && rv_q[slot][eg_c]) ? reth_q[slot][eg_c] : '0;
  assign kind     = em_ack_q ? KindAck : (em_reth_q ? KindReth : KindData);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      m_data_q <= {reth_out,
                   em_ack_q ? {SumW{1'b0}} : sum_q,
                   em_ack_q ? {WiW{1'b0}} : wi_q,
                   psn_q,
                   em_ack_q ? OpAck : op_q,
                   egress};
      m_user_q <= {rv_out, kind};
      m_last_q <= (em_idx_q == em_n_q - IdxW'(1));
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  ap_mod_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni) acc |=> (state_q == StMod))
    else $error("accepted beat not followed by update cycle");

  ap_emit_index: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (state_q == StEmit) |-> (em_idx_q < em_n_q))
    else $error("emit index beyond result count");

  ap_no_out_in_init: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (state_q == StInit) |-> !m_valid_q)
    else $error("result beat during clearing pass");

  ap_scrub_yields: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (scr_rd_q && scr_hit_q) |-> !scr_we)
    else $error("stale scrub write after item update");

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the in-network sum aggregator. A scoreboard tracks
// slot sums, arrival bits, degree counts and kept RETH values, predicts every
// result beat of each accepted input beat, and compares the result stream in
// order. Aggregation rounds (child packets, retransmissions, parent data,
// ACKs) run as root and as non-root, mixed with malformed beats, bursty input
// and a stalling output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import insa_pkg::*;

  localparam int LimitCycles = 600000;
  localparam int DrainCycles = 24;

  typedef struct packed {
    logic [PortW-1:0] port;
    logic [OpW-1:0]   op;
    logic [PsnW-1:0]  psn;
    logic [WiW-1:0]   wi;
    logic [SumW-1:0]  word;
    logic [63:0]      addr;
    logic [31:0]      key;
    logic [31:0]      len;
  } word_beat_t;

  typedef struct packed {
    logic [PortW-1:0] port;
    kind_e            kind;
    logic [OpW-1:0]   op;
    logic [PsnW-1:0]  psn;
    logic [WiW-1:0]   wi;
    logic [SumW-1:0]  word;
    logic             rv;
    logic [RethW-1:0] reth;
    logic             last;
  } result_beat_t;

  // Slot-pool state mirror and queue of expected result beats
  class AggScoreboard;
    bit                 root_mode;
    logic [FanIn:0]     arrivals[Slots];
    logic [DegW-1:0]    degree[Slots];
    logic [SumW-1:0]    sums[Slots][PayloadWords];
    logic [RethW-1:0]   kept[Slots][FanIn];
    action_t            latch;
    result_beat_t       awaited[$];
    int                 errors;

    function new();
      root_mode = 0;
      latch     = '0;
      errors    = 0;
      for (int s = 0; s < Slots; s++) wipe_slot(s);
    endfunction

    function void wipe_slot(int s);
      arrivals[s] = '0;
      degree[s]   = '0;
      for (int c = 0; c < FanIn; c++) kept[s][c] = '0;
      for (int w = 0; w < PayloadWords; w++) sums[s][w] = '0;
    endfunction

    function void queue_result(int port, kind_e kind, word_beat_t b, int slot,
                               bit with_reth);
      result_beat_t r;
      r.port = PortW'(port);
      r.kind = kind;
      r.op   = b.op;
      r.psn  = b.psn;
      r.wi   = b.wi;
      r.word = sums[slot][b.wi];
      r.rv   = with_reth;
      r.reth = with_reth ? kept[slot][port] : '0;
      r.last = 1'b0;
      awaited.push_back(r);
    endfunction

    // Predict the results of one accepted beat
    function void note_input(word_beat_t b);
      bit                data_op, write_op;
      int                slot, n, all_kids;
      logic [FanIn:0]    bits;
      act_e              act;
      kind_e             kind;
      result_beat_t      r;
      data_op  = b.op inside {OpSendFirst, OpSendMiddle, OpSendLast, OpSendOnly,
                              OpWriteMiddle, OpWriteLast};
      write_op = b.op inside {OpWriteFirst, OpWriteOnly};
      slot     = b.psn % Slots;
      all_kids = (1 << FanIn) - 1;
      n        = 0;
      if (b.port > FanIn) return;
      if (b.op == OpAck) begin
        if (b.port >= FanIn) return;
        r      = '0;
        r.port = b.port;
        r.kind = KindAck;
        r.op   = OpAck;
        r.psn  = b.psn;
        r.last = 1'b1;
        awaited.push_back(r);
        return;
      end
      if (!data_op && !write_op) return;
      if (b.wi >= PayloadWords) return;

      if (b.wi == 0) begin
        bits = arrivals[slot];
        if (b.port < FanIn) begin
          degree[slot] = degree[slot] + DegW'(1);
          if (bits[b.port]) begin
            if (bits[FanIn]) act = ActResendChild;
            else if (!root_mode && (bits & all_kids) == all_kids &&
                     (degree[slot] % FanIn) == 0) act = ActResendUp;
            else act = ActNone;
          end else begin
            bits[b.port]  = 1'b1;
            arrivals[slot] = bits;
            if (write_op) kept[slot][b.port] = {b.len, b.key, b.addr};
            if ((bits & all_kids) == all_kids) begin
              if (root_mode) arrivals[slot] = {1'b1, bits[FanIn-1:0]};
              wipe_slot((int'(b.psn) + Window) % Slots);
              act = root_mode ? ActAccBcast : ActAccUp;
            end else begin
              act = ActAcc;
            end
          end
        end else begin
          if (!bits[FanIn] && (bits & all_kids) == all_kids) begin
            arrivals[slot] = {1'b1, bits[FanIn-1:0]};
            act = ActDown;
          end else begin
            act = ActNone;
          end
        end
        latch.valid = 1'b1;
        latch.reth  = write_op;
        latch.act   = act;
      end else if (!latch.valid) begin
        return;
      end

      act  = latch.act;
      kind = latch.reth ? KindReth : KindData;
      if (act inside {ActAcc, ActAccBcast, ActAccUp})
        sums[slot][b.wi] = sums[slot][b.wi] + b.word;
      else if (act == ActDown)
        sums[slot][b.wi] = b.word;

      case (act)
        ActAccBcast, ActDown: begin
          for (int c = 0; c < FanIn; c++) begin
            queue_result(c, kind, b, slot, latch.reth);
            n++;
          end
        end
        ActAccUp, ActResendUp: begin
          queue_result(FanIn, kind, b, slot, 1'b0);
          n++;
        end
        ActResendChild: begin
          if (b.port < FanIn) begin
            queue_result(b.port, kind, b, slot, latch.reth);
            n++;
          end
        end
        default: ;
      endcase
      if (b.wi == PayloadWords - 1) latch = '0;
      if (n > 0) awaited[$].last = 1'b1;
    endfunction

    // Compare one accepted result beat with the oldest prediction
    function void check_result(result_beat_t got);
      result_beat_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %p", got);
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           cfg_valid_i = 1'b0;
  logic           cfg_ready_o;
  logic           cfg_data_i = 1'b0;
  logic           s_axis_tvalid = 1'b0;
  logic           s_axis_tready;
  logic [191:0]   s_axis_tdata = '0;
  logic [7:0]     s_axis_tuser = '0;
  logic           m_axis_tvalid;
  logic           m_axis_tready = 1'b0;
  logic [199:0]   m_axis_tdata;
  logic [2:0]     m_axis_tuser;
  logic           m_axis_tlast;

  AggScoreboard   sb = new();
  int             beats_sent = 0;
  int             cycle_count = 0;
  int             burst_left = 0;
  bit             hold_off = 1'b0;
  bit             hold_done = 1'b0;
  logic [PsnW-1:0] next_psn = '0;

  in_network_sum_aggregator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  // Predict on every accepted input beat
  always @(posedge clk_i) begin
    word_beat_t b;
    if (s_axis_tvalid && s_axis_tready) begin
      b.port = s_axis_tdata[1:0];
      b.psn  = s_axis_tdata[25:2];
      b.wi   = s_axis_tdata[31:26];
      b.word = s_axis_tdata[63:32];
      b.addr = s_axis_tdata[127:64];
      b.key  = s_axis_tdata[159:128];
      b.len  = s_axis_tdata[191:160];
      b.op   = s_axis_tuser;
      sb.note_input(b);
    end
  end

  // Check every accepted result beat
  always @(posedge clk_i) begin
    result_beat_t r;
    if (m_axis_tvalid && m_axis_tready) begin
      r.port = m_axis_tdata[1:0];
      r.op   = m_axis_tdata[9:2];
      r.psn  = m_axis_tdata[33:10];
      r.wi   = m_axis_tdata[39:34];
      r.word = m_axis_tdata[71:40];
      r.reth = m_axis_tdata[199:72];
      r.kind = kind_e'(m_axis_tuser[1:0]);
      r.rv   = m_axis_tuser[2];
      r.last = m_axis_tlast;
      sb.check_result(r);
    end
  end

  // Output stall pattern: switch between free-running and stall-heavy modes
  int stall_mode = 0;
  int mode_left = 0;
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left  <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    if (hold_off) m_axis_tready <= 1'b0;
    else case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 9) < 7);
      default: m_axis_tready <= ($urandom_range(0, 9) < 3);
    endcase
  end

  // Long output hold-off once the random traffic is under way
  initial begin
    wait (beats_sent >= 150);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off  = 1'b0;
    hold_done = 1'b1;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LimitCycles) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one beat and hold it until accepted; gaps fall between bursts
  task automatic send_beat(word_beat_t b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b.len, b.key, b.addr, b.word, b.wi, b.psn, b.port};
    s_axis_tuser  <= b.op;
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
  endtask

  function automatic word_beat_t make_beat(int port, logic [7:0] op,
                                           logic [PsnW-1:0] psn, int wi);
    word_beat_t b;
    b.port = PortW'(port);
    b.op   = op;
    b.psn  = psn;
    b.wi   = WiW'(wi);
    b.word = $urandom;
    b.addr = {$urandom, $urandom};
    b.key  = $urandom;
    b.len  = $urandom;
    return b;
  endfunction

  function automatic logic [7:0] pick_first_op();
    case ($urandom_range(0, 3))
      0: return OpWriteFirst;
      1: return OpWriteOnly;
      2: return OpSendFirst;
      default: return OpSendOnly;
    endcase
  endfunction

  function automatic logic [7:0] pick_later_op();
    case ($urandom_range(0, 4))
      0: return OpSendMiddle;
      1: return OpSendLast;
      2: return OpWriteMiddle;
      3: return OpWriteLast;
      default: return OpSendFirst;
    endcase
  endfunction

  // One packet of nwords payload beats from one port
  task automatic send_packet(int port, logic [PsnW-1:0] psn, int nwords);
    send_beat(make_beat(port, pick_first_op(), psn, 0));
    for (int w = 1; w < nwords; w++) send_beat(make_beat(port, pick_later_op(), psn, w));
  endtask

  // Wait until every predicted beat has come out, then let the pipe settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.awaited.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_root(bit value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.root_mode = value;
    cfg_valid_i <= 1'b0;
  endtask

  // One aggregation round on a slot, with retransmissions, parent data and noise
  task automatic agg_round();
    logic [PsnW-1:0] psn;
    int              len, first;
    word_beat_t      b;
    if ($urandom_range(0, 9) == 0) next_psn = PsnW'($urandom);
    psn      = next_psn;
    next_psn = next_psn + PsnW'(1);
    len      = $urandom_range(1, 4);
    first    = $urandom_range(0, FanIn - 1);
    for (int k = 0; k < FanIn; k++) begin
      send_packet((first + k) % FanIn, psn, len);
      if ($urandom_range(0, 4) == 0) send_packet($urandom_range(0, FanIn - 1), psn, len);
    end
    if ($urandom_range(0, 2) != 0) send_packet(FanIn, psn, len);
    if ($urandom_range(0, 3) == 0) send_packet($urandom_range(0, FanIn - 1), psn, len);
    if ($urandom_range(0, 3) == 0)
      send_beat(make_beat($urandom_range(0, FanIn), OpAck, psn, 0));
    // Noise: random fields, unknown opcodes, bad port, stray words
    if ($urandom_range(0, 3) == 0) begin
      b    = make_beat($urandom_range(0, 3), 8'($urandom), PsnW'($urandom),
                       $urandom_range(0, 63));
      if ($urandom_range(0, 1)) b.op = 8'($urandom_range(0, 11));
      send_beat(b);
    end
  endtask

  initial begin
    word_beat_t b;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_root(1'b0);

    // Directed: wrap of a sum, RETH keep, parent data, resends, ACKs, bad beats
    b = make_beat(0, OpWriteOnly, '0, 0);
    b.word = '1; b.addr = '1; b.key = '1; b.len = '1;
    send_beat(b);
    b = make_beat(1, OpWriteFirst, '0, 0);
    b.word = 32'd1; b.addr = '0; b.key = '0; b.len = '0;
    send_beat(b);
    send_beat(make_beat(0, OpWriteMiddle, '0, 1));
    send_beat(make_beat(FanIn, OpSendOnly, '0, 0));
    send_beat(make_beat(FanIn, OpSendOnly, '0, 0));
    send_beat(make_beat(0, OpWriteOnly, '0, 0));
    send_beat(make_beat(1, OpSendFirst, '0, 0));
    send_beat(make_beat(0, OpAck, 24'hFFFFFF, 0));
    send_beat(make_beat(1, OpAck, '0, 0));
    send_beat(make_beat(FanIn, OpAck, '0, 0));
    send_beat(make_beat(3, OpSendOnly, '0, 0));
    send_beat(make_beat(0, 8'h55, '0, 0));
    send_beat(make_beat(0, 8'hFF, '0, 0));
    send_beat(make_beat(0, OpSendOnly, 24'hFFFFFF, 0));
    send_beat(make_beat(1, OpSendOnly, 24'hFFFFFF, 0));
    send_beat(make_beat(0, OpSendOnly, 24'hFFFFFF, 0));
    send_beat(make_beat(1, OpSendOnly, 24'hFFFFFF, 0));
    send_beat(make_beat(1, OpSendLast, 24'hFFFFFF, 63));
    send_beat(make_beat(FanIn, OpSendMiddle, 24'hFFFFFF, 5));

    // Full-length packet: the latch returns to idle after the last word
    send_packet(0, 24'd3, PayloadWords);

    // Random rounds as non-root, root, then non-root again
    while (beats_sent < 160) agg_round();
    write_root(1'b1);
    while (beats_sent < 270) agg_round();
    write_root(1'b0);
    while (beats_sent < 370 || !hold_done) agg_round();

    drain();
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
